[rtl/core/stk_pkg.sv]
// Package for the SQL token scanner: token kinds, scan modes, keyword table,
// token record types and character class helpers. No dependencies.
`default_nettype none

package stk_pkg;

	localparam int LINE_BITS   = 16;
	localparam int COLUMN_BITS = 16;
	localparam int OFFSET_BITS = 32;
	localparam int KIND_BITS   = 5;
	localparam int NUM_KW      = 15;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [KIND_BITS-1:0] K_END     = 5'd0;
	localparam logic [KIND_BITS-1:0] K_IDENT   = 5'd1;
	localparam logic [KIND_BITS-1:0] K_KW_BASE = 5'd2;
	localparam logic [KIND_BITS-1:0] K_NUMBER  = 5'd17;
	localparam logic [KIND_BITS-1:0] K_STRING  = 5'd18;
	localparam logic [KIND_BITS-1:0] K_STAR    = 5'd19;
	localparam logic [KIND_BITS-1:0] K_COMMA   = 5'd20;
	localparam logic [KIND_BITS-1:0] K_LPAREN  = 5'd21;
	localparam logic [KIND_BITS-1:0] K_RPAREN  = 5'd22;
	localparam logic [KIND_BITS-1:0] K_EQ      = 5'd23;
	localparam logic [KIND_BITS-1:0] K_NE      = 5'd24;
	localparam logic [KIND_BITS-1:0] K_LT      = 5'd25;
	localparam logic [KIND_BITS-1:0] K_LE      = 5'd26;
	localparam logic [KIND_BITS-1:0] K_GT      = 5'd27;
	localparam logic [KIND_BITS-1:0] K_GE      = 5'd28;
	localparam logic [KIND_BITS-1:0] K_INVALID = 5'd29;

	localparam logic [NUM_KW-1:0] ALL_KEYWORDS = '1;

	typedef enum logic [6:0] {
		MODE_IDLE    = 7'b0000001,
		MODE_IDENT   = 7'b0000010,
		MODE_NUMBER  = 7'b0000100,
		MODE_STRING  = 7'b0001000,
		MODE_BANG    = 7'b0010000,
		MODE_LESS    = 7'b0100000,
		MODE_GREATER = 7'b1000000
	} mode_t;

	localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
		'{"C","R","E","A","T","E",8'h0,8'h0},
		'{"T","A","B","L","E",8'h0,8'h0,8'h0},
		'{"I","N","S","E","R","T",8'h0,8'h0},
		'{"I","N","T","O",8'h0,8'h0,8'h0,8'h0},
		'{"S","E","L","E","C","T",8'h0,8'h0},
		'{"F","R","O","M",8'h0,8'h0,8'h0,8'h0},
		'{"W","H","E","R","E",8'h0,8'h0,8'h0},
		'{"U","P","D","A","T","E",8'h0,8'h0},
		'{"S","E","T",8'h0,8'h0,8'h0,8'h0,8'h0},
		'{"D","E","L","E","T","E",8'h0,8'h0},
		'{"V","A","L","U","E","S",8'h0,8'h0},
		'{"A","N","D",8'h0,8'h0,8'h0,8'h0,8'h0},
		'{"O","R",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
		'{"I","N","T",8'h0,8'h0,8'h0,8'h0,8'h0},
		'{"V","A","R","C","H","A","R",8'h0}
	};

	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd6, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd5, 4'd6,
		4'd3, 4'd6, 4'd6, 4'd3, 4'd2, 4'd3, 4'd7
	};

	typedef struct packed {
		logic [KIND_BITS-1:0]   kind;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] column;
		logic [OFFSET_BITS-1:0] offset;
		logic [OFFSET_BITS-1:0] length;
	} token_t;

	// Tokens caused by one text byte: one or two.
	typedef struct packed {
		token_t first;
		token_t second;
		logic   two;
	} bundle_t;

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	// Drop keywords that cannot match once byte up lands at position len.
	function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] cand,
			input logic [OFFSET_BITS-1:0] len, input logic [7:0] up);
		logic [NUM_KW-1:0] r;
		r = cand;
		for (int k = 0; k < NUM_KW; k++) begin
			if (len >= OFFSET_BITS'(KW_LEN[k]) || KW_TEXT[k][len[2:0]] != up)
				r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [KIND_BITS-1:0] ident_kind(input logic [NUM_KW-1:0] cand,
			input logic [OFFSET_BITS-1:0] len);
		logic [KIND_BITS-1:0] r;
		r = K_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (cand[k] && len == OFFSET_BITS'(KW_LEN[k]))
				r = K_KW_BASE + KIND_BITS'(k);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/stk_front.sv]
// Front end of the SQL token scanner: takes text bytes, keeps the scan state
// and builds the one or two tokens a byte causes. Depends on stk_pkg.
`default_nettype none

module stk_front
	import stk_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	output logic            has_tok,
	output bundle_t         bundle
);

	mode_t                  mode_q, mode_n;
	logic                   quote_q, quote_n;
	logic [NUM_KW-1:0]      cand_q, cand_n;
	logic [LINE_BITS-1:0]   cur_line_q, cur_line_n, tok_line_q, tok_line_n;
	logic [COLUMN_BITS-1:0] cur_col_q, cur_col_n, tok_col_q, tok_col_n;
	logic [OFFSET_BITS-1:0] cur_off_q, cur_off_n, tok_off_q, tok_off_n;
	logic [OFFSET_BITS-1:0] tok_len_q, tok_len_n;

	always_comb begin
		logic [7:0]             up;
		logic                   is_ws, is_idch;
		logic [LINE_BITS-1:0]   adv_line;
		logic [COLUMN_BITS-1:0] adv_col;
		logic [OFFSET_BITS-1:0] adv_off, len_inc;
		logic                   st_emit, do_start, used;
		logic [KIND_BITS-1:0]   st_kind;
		token_t                 pend, st_tok;

		up      = (text_byte >= "a" && text_byte <= "z") ? text_byte - 8'd32 : text_byte;
		is_ws   = text_byte == " " || text_byte == 8'h09 || text_byte == 8'h0D
			|| text_byte == 8'h0A;
		is_idch = is_alpha(text_byte) || is_digit(text_byte) || text_byte == "_";
		adv_off = (cur_off_q != '1) ? cur_off_q + 1'b1 : cur_off_q;
		len_inc = (tok_len_q != '1) ? tok_len_q + 1'b1 : tok_len_q;
		if (text_byte == 8'h0A) begin
			adv_line = (cur_line_q != '1) ? cur_line_q + 1'b1 : cur_line_q;
			adv_col  = COLUMN_BITS'(1);
		end else begin
			adv_line = cur_line_q;
			adv_col  = (cur_col_q != '1) ? cur_col_q + 1'b1 : cur_col_q;
		end

		pend = '{kind: K_INVALID, line: tok_line_q, column: tok_col_q,
			offset: tok_off_q, length: tok_len_q};
		st_tok = '{kind: K_INVALID, line: cur_line_q, column: cur_col_q,
			offset: cur_off_q, length: OFFSET_BITS'(1)};

		mode_n    = mode_q;
		quote_n   = quote_q;
		cand_n    = cand_q;
		cur_line_n = cur_line_q;
		cur_col_n  = cur_col_q;
		cur_off_n  = cur_off_q;
		tok_line_n = tok_line_q;
		tok_col_n  = tok_col_q;
		tok_off_n  = tok_off_q;
		tok_len_n  = tok_len_q;
		bundle    = '0;
		used      = 1'b0;
		do_start  = 1'b0;
		st_emit   = 1'b0;
		st_kind   = K_INVALID;

		if (end_of_text) begin
			used = 1'b1;
			bundle.first = pend;
			case (mode_q)
				MODE_IDENT:   bundle.first.kind = ident_kind(cand_q, tok_len_q);
				MODE_NUMBER:  bundle.first.kind = K_NUMBER;
				MODE_STRING:  bundle.first.kind = K_INVALID;
				MODE_BANG:    bundle.first.length = OFFSET_BITS'(1);
				MODE_LESS: begin
					bundle.first.kind   = K_LT;
					bundle.first.length = OFFSET_BITS'(1);
				end
				MODE_GREATER: begin
					bundle.first.kind   = K_GT;
					bundle.first.length = OFFSET_BITS'(1);
				end
				default:      used = 1'b0;
			endcase
			if (used) begin
				bundle.two    = 1'b1;
				bundle.second = '{kind: K_END, line: cur_line_q, column: cur_col_q,
					offset: cur_off_q, length: '0};
			end else begin
				bundle.first = '{kind: K_END, line: cur_line_q, column: cur_col_q,
					offset: cur_off_q, length: '0};
			end
			used       = 1'b1;
			mode_n     = MODE_IDLE;
			quote_n    = 1'b0;
			cand_n     = ALL_KEYWORDS;
			cur_line_n = LINE_BITS'(1);
			cur_col_n  = COLUMN_BITS'(1);
			cur_off_n  = '0;
			tok_line_n = LINE_BITS'(1);
			tok_col_n  = COLUMN_BITS'(1);
			tok_off_n  = '0;
			tok_len_n  = '0;
		end else begin
			case (mode_q)
				MODE_IDENT: begin
					if (is_idch) begin
						cand_n    = kw_filter(cand_q, tok_len_q, up);
						tok_len_n = len_inc;
					end else begin
						bundle.first      = pend;
						bundle.first.kind = ident_kind(cand_q, tok_len_q);
						used     = 1'b1;
						do_start = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(text_byte) || text_byte == ".") begin
						tok_len_n = len_inc;
					end else begin
						bundle.first      = pend;
						bundle.first.kind = K_NUMBER;
						used     = 1'b1;
						do_start = 1'b1;
					end
				end
				MODE_STRING: begin
					if (text_byte == (quote_q ? 8'h22 : 8'h27)) begin
						bundle.first      = pend;
						bundle.first.kind = K_STRING;
						used   = 1'b1;
						mode_n = MODE_IDLE;
					end else begin
						tok_len_n = len_inc;
					end
				end
				MODE_BANG, MODE_LESS, MODE_GREATER: begin
					bundle.first = pend;
					used = 1'b1;
					if (text_byte == "=" || (mode_q == MODE_LESS && text_byte == ">")) begin
						bundle.first.length = OFFSET_BITS'(2);
						mode_n = MODE_IDLE;
						if (mode_q == MODE_GREATER)
							bundle.first.kind = K_GE;
						else if (mode_q == MODE_LESS && text_byte == "=")
							bundle.first.kind = K_LE;
						else
							bundle.first.kind = K_NE;
					end else begin
						bundle.first.length = OFFSET_BITS'(1);
						if (mode_q == MODE_LESS)
							bundle.first.kind = K_LT;
						else if (mode_q == MODE_GREATER)
							bundle.first.kind = K_GT;
						do_start = 1'b1;
					end
				end
				default: do_start = 1'b1;
			endcase

			if (do_start) begin
				tok_line_n = cur_line_q;
				tok_col_n  = cur_col_q;
				tok_off_n  = cur_off_q;
				tok_len_n  = '0;
				mode_n     = MODE_IDLE;
				if (is_ws) begin
					mode_n = MODE_IDLE;
				end else if (is_alpha(text_byte) || text_byte == "_") begin
					mode_n    = MODE_IDENT;
					cand_n    = kw_filter(ALL_KEYWORDS, '0, up);
					tok_len_n = OFFSET_BITS'(1);
				end else if (is_digit(text_byte)) begin
					mode_n    = MODE_NUMBER;
					tok_len_n = OFFSET_BITS'(1);
				end else if (text_byte == 8'h27 || text_byte == 8'h22) begin
					mode_n    = MODE_STRING;
					quote_n   = text_byte == 8'h22;
					tok_off_n = adv_off;
				end else if (text_byte == "!" || text_byte == "<" || text_byte == ">") begin
					mode_n    = (text_byte == "!") ? MODE_BANG
						: (text_byte == "<") ? MODE_LESS : MODE_GREATER;
					tok_len_n = OFFSET_BITS'(1);
				end else begin
					st_emit = 1'b1;
					case (text_byte)
						"*":     st_kind = K_STAR;
						",":     st_kind = K_COMMA;
						"(":     st_kind = K_LPAREN;
						")":     st_kind = K_RPAREN;
						"=":     st_kind = K_EQ;
						default: st_kind = K_INVALID;
					endcase
				end
			end

			if (st_emit) begin
				st_tok.kind = st_kind;
				if (used) begin
					bundle.two    = 1'b1;
					bundle.second = st_tok;
				end else begin
					bundle.first = st_tok;
				end
				used = 1'b1;
			end

			cur_line_n = adv_line;
			cur_col_n  = adv_col;
			cur_off_n  = adv_off;
		end
		has_tok = used;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			quote_q    <= 1'b0;
			cand_q     <= ALL_KEYWORDS;
			cur_line_q <= LINE_BITS'(1);
			cur_col_q  <= COLUMN_BITS'(1);
			cur_off_q  <= '0;
			tok_line_q <= LINE_BITS'(1);
			tok_col_q  <= COLUMN_BITS'(1);
			tok_off_q  <= '0;
			tok_len_q  <= '0;
		end else if (take) begin
			mode_q     <= mode_n;
			quote_q    <= quote_n;
			cand_q     <= cand_n;
			cur_line_q <= cur_line_n;
			cur_col_q  <= cur_col_n;
			cur_off_q  <= cur_off_n;
			tok_line_q <= tok_line_n;
			tok_col_q  <= tok_col_n;
			tok_off_q  <= tok_off_n;
			tok_len_q  <= tok_len_n;
		end
	end

endmodule

`default_nettype wire

[rtl/core/stk_queue.sv]
// Short queue of token bundles between the scanner front end and the output
// back end. Depends on stk_pkg.
`default_nettype none

module stk_queue
	import stk_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire bundle_t wr_data,
	input  wire logic    pop,
	output logic         full,
	output logic         not_empty,
	output bundle_t      rd_data
);

	bundle_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign full      = cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_BITS+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("pop from empty queue");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count not advanced");
`endif

endmodule

`default_nettype wire

[rtl/core/stk_back.sv]
// Back end of the SQL token scanner: drains token bundles from the queue and
// presents one token per request on the output register. Depends on stk_pkg.
`default_nettype none

module stk_back
	import stk_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_avail,
	input  wire bundle_t                q_data,
	output logic                        q_pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [KIND_BITS-1:0]        token_kind,
	output logic [LINE_BITS-1:0]        first_line,
	output logic [COLUMN_BITS-1:0]      start_column,
	output logic [OFFSET_BITS-1:0]      text_offset,
	output logic [OFFSET_BITS-1:0]      text_length,
	output logic                        last_of_run
);

	logic   valid_q, last_q, pend_q;
	token_t out_q, second_q;
	logic   load;

	assign load  = !valid_q || out_ready;
	assign q_pop = load && !pend_q && q_avail;

	assign out_valid    = valid_q;
	assign token_kind   = out_q.kind;
	assign first_line   = out_q.line;
	assign start_column = out_q.column;
	assign text_offset  = out_q.offset;
	assign text_length  = out_q.length;
	assign last_of_run  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= q_avail;
				pend_q  <= q_avail && q_data.two;
			end
		end
	end

	// payload: advance with the handshake, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_q  <= second_q;
				last_q <= 1'b1;
			end else if (q_avail) begin
				out_q    <= q_data.first;
				last_q   <= !q_data.two;
				second_q <= q_data.second;
			end
		end
	end

`ifndef SYNTHESIS
	a_pend_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> valid_q) else $error("second token pending without first");
	a_pend_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && valid_q) |-> !last_q) else $error("first of pair marked last");
	a_no_pop_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !q_pop) else $error("pop while second token pending");
`endif

endmodule

`default_nettype wire

[rtl/core/sql_token_scanner.sv]
// SQL token scanner top level: scanner front end, bundle queue and output
// back end. Depends on stk_pkg, stk_front, stk_queue, stk_back.
//
// Use: feed SQL text one byte per request on the input channel (text_byte,
// end_of_text, in_valid/in_ready). Tokens leave on the output channel
// (token_kind, first_line, start_column, text_offset, text_length,
// last_of_run, out_valid/out_ready). A request with end_of_text set flushes
// any open token, gives the end token and returns the scanner to reset state.
// Each byte yields zero, one or two tokens; last_of_run marks the final token
// of a request. A byte's tokens enter the four-entry queue at the edge that
// accepts it and move from there into the output register. The scanner takes
// one byte per cycle while the queue has room; the output side gives one token
// per cycle while out_ready is high, so bytes that yield two tokens cost the
// output a second transfer, which the queue absorbs. If the receiver stalls,
// the output register holds, the queue fills and in_ready falls when full.
// Reset clears scan state, positions (line 1, column 1, offset 0), the queue
// and the output valid.
`default_nettype none

module sql_token_scanner
	import stk_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             text_byte,
	input  wire logic                   end_of_text,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [KIND_BITS-1:0]        token_kind,
	output logic [LINE_BITS-1:0]        first_line,
	output logic [COLUMN_BITS-1:0]      start_column,
	output logic [OFFSET_BITS-1:0]      text_offset,
	output logic [OFFSET_BITS-1:0]      text_length,
	output logic                        last_of_run
);

	logic    take, has_tok, full, q_avail, q_pop;
	bundle_t fr_bundle, q_data;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	stk_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.has_tok     (has_tok),
		.bundle      (fr_bundle)
	);

	stk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && has_tok),
		.wr_data   (fr_bundle),
		.pop       (q_pop),
		.full      (full),
		.not_empty (q_avail),
		.rd_data   (q_data)
	);

	stk_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_avail      (q_avail),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.first_line   (first_line),
		.start_column (start_column),
		.text_offset  (text_offset),
		.text_length  (text_length),
		.last_of_run  (last_of_run)
	);

`ifndef SYNTHESIS
	a_eot_gives_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(take && end_of_text) |-> has_tok) else $error("end marker gave no token");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> in_ready) else $error("input stalled with queue room");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("output dropped");
`endif

endmodule

`default_nettype wire
